// ===== sv/svt_pkg.sv =====
// ----------------------------------------------------------------------------
// svt_pkg
// shared types and constants for the sorted value table
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 7;
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_POP    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } t_state;

    // what every cell does at the update edge
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_INS  = 2'd1,
        SH_DEL  = 2'd2,
        SH_POP  = 2'd3
    } t_shift;

    typedef struct packed {
        t_shift                   mode;
        logic signed [VAL_W-1:0]  value;
        logic [CNT_W-1:0]         count;
    } t_cell_ctl;

endpackage

// ===== sv/svt_if.sv =====
// ----------------------------------------------------------------------------
// svt request and response channels
// valid/ready channels carrying table requests and their responses
// ----------------------------------------------------------------------------
interface svt_req_if;
    logic                                 valid;
    logic                                 ready;
    svt_pkg::t_opcode                     opcode;
    logic signed [svt_pkg::VAL_W-1:0]     value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface svt_rsp_if;
    logic                                 valid;
    logic                                 ready;
    svt_pkg::t_status                     status;
    logic signed [svt_pkg::VAL_W-1:0]     popped_value;
    logic [svt_pkg::OCC_W-1:0]            occupancy;

    modport source (output valid, output status, output popped_value, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input occupancy,
                    output ready);
endinterface

// ===== sv/svt_cell.sv =====
// ----------------------------------------------------------------------------
// svt_cell
// one slot of the sorted chain: compares against the broadcast value and
// takes its own value, the broadcast value, or its left or right neighbour's value
// ----------------------------------------------------------------------------
module svt_cell (
    input  logic                                i_clk,
    input  svt_pkg::t_cell_ctl                  i_ctl,
    input  logic [svt_pkg::CNT_W-1:0]           i_idx,
    input  logic signed [svt_pkg::VAL_W-1:0]    i_left_val,
    input  logic signed [svt_pkg::VAL_W-1:0]    i_right_val,
    input  logic                                i_prev_lt,
    output logic signed [svt_pkg::VAL_W-1:0]    o_val,
    output logic                                o_lt,
    output logic                                o_eq
);

    logic signed [svt_pkg::VAL_W-1:0] r_val;
    logic signed [svt_pkg::VAL_W-1:0] n_val;
    logic                             w_vld;

    assign w_vld = i_idx < i_ctl.count;
    assign o_lt  = w_vld && (r_val < i_ctl.value);
    assign o_eq  = w_vld && (r_val == i_ctl.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.mode)
            svt_pkg::SH_INS: begin
                // open a gap at the first slot not smaller than the value
                if (!o_lt) begin
                    n_val = i_prev_lt ? i_ctl.value : i_left_val;
                end
            end
            svt_pkg::SH_DEL: begin
                if (!o_lt) begin
                    n_val = i_right_val;
                end
            end
            svt_pkg::SH_POP: n_val = i_right_val;
            default:         n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== sv/sorted_value_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_value_table_core
// ascending table of signed values held in a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// request path: an accepted request is held in the request register while the
//   control state is busy; its response is registered once the chain updates
// acceptance: a new request is taken only when idle, after the single update pass of
//   the cell chain (compare, found reduction and shift together); a
//   response not yet taken holds back the update and so the next request
// reset: synchronous active low, clears the entry count and the handshake
//   state; cell contents are left as they are and are only read below count
// ----------------------------------------------------------------------------
module sorted_value_table_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    svt_req_if.sink       i_req,
    svt_rsp_if.source     o_rsp
);

    localparam int CAP = svt_pkg::CAPACITY;

    // request register and control state
    svt_pkg::t_state                   r_state;
    svt_pkg::t_state                   n_state;
    svt_pkg::t_opcode                  r_op;
    logic signed [svt_pkg::VAL_W-1:0]  r_value;
    logic [svt_pkg::CNT_W-1:0]         r_count;
    logic [svt_pkg::CNT_W-1:0]         n_count;

    // response register, parts the chain from the response channel
    logic                              r_out_valid;
    logic                              n_out_valid;
    svt_pkg::t_status                  r_status;
    svt_pkg::t_status                  n_status;
    logic signed [svt_pkg::VAL_W-1:0]  r_popped;
    logic signed [svt_pkg::VAL_W-1:0]  n_popped;

    // chain wiring
    logic signed [svt_pkg::VAL_W-1:0]  w_cell_val [CAP];
    logic                              w_cell_lt  [CAP];
    logic [CAP-1:0]                    w_cell_eq;
    svt_pkg::t_cell_ctl                w_ctl;

    logic w_accept;
    logic w_apply;
    logic w_full;
    logic w_empty;
    logic w_found;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_full   = r_count == svt_pkg::CNT_W'(CAP);
    assign w_empty  = r_count == '0;
    // sorted contents: any equal entry marks a hit
    assign w_found  = |w_cell_eq;

    // update only once the response register is free to take the answer
    assign w_apply  = (r_state == svt_pkg::S_BUSY) && (!r_out_valid || o_rsp.ready);

    assign i_req.ready = r_state == svt_pkg::S_IDLE;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_status    = r_status;
        n_popped    = r_popped;
        n_out_valid = r_out_valid && !o_rsp.ready;
        w_ctl.mode  = svt_pkg::SH_HOLD;
        w_ctl.value = r_value;
        w_ctl.count = r_count;

        case (r_state)
            svt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = svt_pkg::S_BUSY;
                end
            end
            svt_pkg::S_BUSY: begin
                if (w_apply) begin
                    n_state     = svt_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                    n_popped    = '0;
                    n_status    = svt_pkg::STS_OK;
                    case (r_op)
                        svt_pkg::OP_INSERT: begin
                            if (w_full) begin
                                n_status = svt_pkg::STS_FULL;
                            end else begin
                                w_ctl.mode = svt_pkg::SH_INS;
                                n_count    = r_count + 1'b1;
                            end
                        end
                        svt_pkg::OP_SEARCH: begin
                            if (!w_found) begin
                                n_status = svt_pkg::STS_NOT_FOUND;
                            end
                        end
                        svt_pkg::OP_DELETE: begin
                            if (w_found) begin
                                w_ctl.mode = svt_pkg::SH_DEL;
                                n_count    = r_count - 1'b1;
                            end else begin
                                n_status = svt_pkg::STS_NOT_FOUND;
                            end
                        end
                        svt_pkg::OP_POP: begin
                            if (w_empty) begin
                                n_status = svt_pkg::STS_EMPTY;
                            end else begin
                                // head cell holds the smallest entry
                                w_ctl.mode = svt_pkg::SH_POP;
                                n_popped   = w_cell_val[0];
                                n_count    = r_count - 1'b1;
                            end
                        end
                        default: n_status = svt_pkg::STS_OK;
                    endcase
                end
            end
            default: n_state = svt_pkg::S_IDLE;
        endcase
    end

    // the chain: each cell sees both neighbours, the ends see themselves
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic signed [svt_pkg::VAL_W-1:0] w_left;
        logic signed [svt_pkg::VAL_W-1:0] w_right;
        logic                             w_prev_lt;

        if (g == 0) begin : g_head
            assign w_left    = w_cell_val[g];
            assign w_prev_lt = 1'b1;
        end else begin : g_body
            assign w_left    = w_cell_val[g-1];
            assign w_prev_lt = w_cell_lt[g-1];
        end

        if (g == CAP - 1) begin : g_tail
            assign w_right = w_cell_val[g];
        end else begin : g_inner
            assign w_right = w_cell_val[g+1];
        end

        svt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_idx       (svt_pkg::CNT_W'(g)),
            .i_left_val  (w_left),
            .i_right_val (w_right),
            .i_prev_lt   (w_prev_lt),
            .o_val       (w_cell_val[g]),
            .o_lt        (w_cell_lt[g]),
            .o_eq        (w_cell_eq[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_req.opcode;
            r_value <= i_req.value;
        end
        r_status <= n_status;
        r_popped <= n_popped;
    end

    logic [svt_pkg::OCC_W-1:0] r_occ;

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_occ <= svt_pkg::OCC_W'(n_count);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_value = r_popped;
    assign o_rsp.occupancy    = r_occ;

endmodule
